### hdl/affine_transform_builder_2d_macros.svh
// Assertion macros used by the top-level RTL file of the affine transform builder.
`ifndef AFFINE_TRANSFORM_BUILDER_2D_MACROS_SVH
`define AFFINE_TRANSFORM_BUILDER_2D_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATB2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atb2d: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATB2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atb2d: next-cycle check failed");

`endif

### hdl/atb2d_pkg.sv
package atb2d_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ROT_W          = 16;
  localparam int unsigned ANGLE_W        = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam int unsigned CORDIC_STAGES = 30;
  localparam int unsigned CORDIC_FRAC   = 30;
  localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
  localparam logic signed [31:0] CORDIC_ONE      = 32'sd1073741824;

  // Input word to done strobe: angle register, CORDIC cells, quadrant stage,
  // and five stages in the scale unit.
  localparam int unsigned LATENCY = CORDIC_STAGES + 7;

  // Wide enough for every value that reaches the output saturation.
  localparam int unsigned SAT_W = 68;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic               valid;
    quad_e              quad;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] scale_x;
    logic signed [DATA_W-1:0] scale_y;
  } payload_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    payload_t           pay;
  } trig_t;

  // Arctangent of 2^-i in units of 2^-32 of a full turn.
  function automatic logic signed [31:0] atan_turn(input int unsigned i);
    logic signed [31:0] r;
    case (i)
      0:       r = 32'sh20000000;
      1:       r = 32'sh12E4051E;
      2:       r = 32'sh09FB385B;
      3:       r = 32'sh051111D4;
      4:       r = 32'sh028B0D43;
      5:       r = 32'sh0145D7E1;
      6:       r = 32'sh00A2F61E;
      7:       r = 32'sh00517C55;
      8:       r = 32'sh0028BE53;
      9:       r = 32'sh00145F2F;
      10:      r = 32'sh000A2F98;
      11:      r = 32'sh000517CC;
      12:      r = 32'sh00028BE6;
      13:      r = 32'sh000145F3;
      14:      r = 32'sh0000A2FA;
      15:      r = 32'sh0000517D;
      16:      r = 32'sh000028BE;
      17:      r = 32'sh0000145F;
      18:      r = 32'sh00000A30;
      19:      r = 32'sh00000518;
      20:      r = 32'sh0000028C;
      21:      r = 32'sh00000146;
      22:      r = 32'sh000000A3;
      23:      r = 32'sh00000051;
      24:      r = 32'sh00000029;
      25:      r = 32'sh00000014;
      26:      r = 32'sh0000000A;
      27:      r = 32'sh00000005;
      28:      r = 32'sh00000003;
      29:      r = 32'sh00000001;
      default: r = 32'sh00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic signed [DATA_W-1:0] r;
    hi = SAT_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
    lo = SAT_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
    if (v > hi) begin
      r = hi[DATA_W-1:0];
    end else if (v < lo) begin
      r = lo[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/atb2d_cordic_cell.sv
module atb2d_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  atb2d_pkg::cordic_t cell_i,
  output atb2d_pkg::cordic_t cell_o
);

  localparam logic signed [31:0] ATAN = atb2d_pkg::atan_turn(STAGE);

  logic                valid_q;
  atb2d_pkg::quad_e    quad_q;
  logic signed [31:0]  x_q, y_q, z_q;
  logic signed [31:0]  x_d, y_d, z_d;
  logic signed [31:0]  dx, dy;

  always_comb begin
    dx = cell_i.y >>> STAGE;
    dy = cell_i.x >>> STAGE;
    // A non-negative residual angle rotates counterclockwise.
    if (!cell_i.z[31]) begin
      x_d = cell_i.x - dx;
      y_d = cell_i.y + dy;
      z_d = cell_i.z - ATAN;
    end else begin
      x_d = cell_i.x + dx;
      y_d = cell_i.y - dy;
      z_d = cell_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= cell_i.quad;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign cell_o = '{valid: valid_q, quad: quad_q, x: x_q, y: y_q, z: z_q};

endmodule

### hdl/atb2d_scale_unit.sv
module atb2d_scale_unit #(
  parameter int unsigned FRAC_BITS = atb2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  atb2d_pkg::trig_t                     trig_i,
  output logic                                 done_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_a_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_b_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  trans_x_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_c_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_d_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  trans_y_o
);

  localparam int unsigned DW      = atb2d_pkg::DATA_W;
  localparam int unsigned CF      = atb2d_pkg::CORDIC_FRAC;
  localparam int unsigned SW      = atb2d_pkg::SAT_W;
  localparam int unsigned PROD1_W = 2 * DW;
  localparam int unsigned COEF_W  = PROD1_W - CF + 1;
  localparam int unsigned PROD2_W = DW + COEF_W;
  localparam int unsigned TERM_W  = PROD2_W - FRAC_BITS;
  localparam int unsigned SUM_W   = TERM_W + 2;
  localparam logic signed [PROD1_W-1:0] ROUND1 = PROD1_W'(1) << (CF - 1);
  localparam logic signed [PROD2_W-1:0] ROUND2 = PROD2_W'(1) << (FRAC_BITS - 1);

  // Stage 1: scale times cosine and sine.
  logic                       v1_q;
  logic signed [PROD1_W-1:0]  p_sxc_q, p_sys_q, p_sxs_q, p_syc_q;
  atb2d_pkg::payload_t        pay1_q;

  // Stage 2: rounded coefficients.
  logic                       v2_q;
  logic signed [COEF_W-1:0]   sxc_q, sys_q, sxs_q, syc_q;
  logic signed [PROD1_W-1:0]  r_sxc, r_sys, r_sxs, r_syc;
  atb2d_pkg::payload_t        pay2_q;

  // Stage 3: origin times coefficients.
  logic                       v3_q;
  logic signed [PROD2_W-1:0]  q_oxa_q, q_oyb_q, q_oxs_q, q_oyd_q;
  logic signed [COEF_W-1:0]   sxc3_q, sys3_q, sxs3_q, syc3_q;
  logic signed [DW-1:0]       px3_q, py3_q;

  // Stage 4: rounded terms and translation sums.
  logic                       v4_q;
  logic signed [PROD2_W-1:0]  r_oxa, r_oyb, r_oxs, r_oyd;
  logic signed [TERM_W-1:0]   t_oxa, t_oyb, t_oxs, t_oyd;
  logic signed [SUM_W-1:0]    tx_d, ty_d, tx_q, ty_q;
  logic signed [COEF_W-1:0]   sxc4_q, sys4_q, sxs4_q, syc4_q;

  // Stage 5: saturated output word.
  logic                       done_q;
  logic signed [DW-1:0]       a_q, b_q, tx5_q, c_q, d_q, ty5_q;

  always_comb begin
    r_sxc = p_sxc_q + ROUND1;
    r_sys = p_sys_q + ROUND1;
    r_sxs = p_sxs_q + ROUND1;
    r_syc = p_syc_q + ROUND1;

    r_oxa = q_oxa_q + ROUND2;
    r_oyb = q_oyb_q + ROUND2;
    r_oxs = q_oxs_q + ROUND2;
    r_oyd = q_oyd_q + ROUND2;
    t_oxa = r_oxa[PROD2_W-1:FRAC_BITS];
    t_oyb = r_oyb[PROD2_W-1:FRAC_BITS];
    t_oxs = r_oxs[PROD2_W-1:FRAC_BITS];
    t_oyd = r_oyd[PROD2_W-1:FRAC_BITS];

    tx_d = SUM_W'(px3_q) - SUM_W'(t_oxa) - SUM_W'(t_oyb);
    ty_d = SUM_W'(py3_q) + SUM_W'(t_oxs) - SUM_W'(t_oyd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= trig_i.valid;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_sxc_q <= $signed(trig_i.pay.scale_x) * $signed(trig_i.cos_v);
    p_sys_q <= $signed(trig_i.pay.scale_y) * $signed(trig_i.sin_v);
    p_sxs_q <= $signed(trig_i.pay.scale_x) * $signed(trig_i.sin_v);
    p_syc_q <= $signed(trig_i.pay.scale_y) * $signed(trig_i.cos_v);
    pay1_q  <= trig_i.pay;

    sxc_q  <= $signed(r_sxc[PROD1_W-1:CF-1]) >>> 1;
    sys_q  <= $signed(r_sys[PROD1_W-1:CF-1]) >>> 1;
    sxs_q  <= $signed(r_sxs[PROD1_W-1:CF-1]) >>> 1;
    syc_q  <= $signed(r_syc[PROD1_W-1:CF-1]) >>> 1;
    pay2_q <= pay1_q;

    q_oxa_q <= $signed(pay2_q.origin_x) * $signed(sxc_q);
    q_oyb_q <= $signed(pay2_q.origin_y) * $signed(sys_q);
    q_oxs_q <= $signed(pay2_q.origin_x) * $signed(sxs_q);
    q_oyd_q <= $signed(pay2_q.origin_y) * $signed(syc_q);
    sxc3_q  <= sxc_q;
    sys3_q  <= sys_q;
    sxs3_q  <= sxs_q;
    syc3_q  <= syc_q;
    px3_q   <= pay2_q.pos_x;
    py3_q   <= pay2_q.pos_y;

    tx_q   <= tx_d;
    ty_q   <= ty_d;
    sxc4_q <= sxc3_q;
    sys4_q <= sys3_q;
    sxs4_q <= sxs3_q;
    syc4_q <= syc3_q;

    a_q   <= atb2d_pkg::sat_word(SW'(sxc4_q));
    b_q   <= atb2d_pkg::sat_word(SW'(sys4_q));
    tx5_q <= atb2d_pkg::sat_word(SW'(tx_q));
    c_q   <= atb2d_pkg::sat_word(-SW'(sxs4_q));
    d_q   <= atb2d_pkg::sat_word(SW'(syc4_q));
    ty5_q <= atb2d_pkg::sat_word(SW'(ty_q));
  end

  assign done_o    = done_q;
  assign coef_a_o  = a_q;
  assign coef_b_o  = b_q;
  assign trans_x_o = tx5_q;
  assign coef_c_o  = c_q;
  assign coef_d_o  = d_q;
  assign trans_y_o = ty5_q;

endmodule

### hdl/affine_transform_builder_2d.sv
// Builds the two upper rows of a 2D affine matrix from one object's
// position, origin, scale and rotation. The block is a fixed pipeline that
// takes one word every clock cycle: busy stays low, so a word is taken
// whenever start is high. Each word passes through the angle register, the
// 30-cell CORDIC chain, the quadrant stage and five multiply, round and
// saturate stages; its result appears on the output ports for a single
// cycle, with done_o high; the receiver cannot stall and must capture it in
// that cycle.
`include "affine_transform_builder_2d_macros.svh"

module affine_transform_builder_2d #(
  parameter int unsigned FRAC_BITS  = atb2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS = atb2d_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [atb2d_pkg::DATA_W-1:0]  pos_x_i,
  input  logic signed [atb2d_pkg::DATA_W-1:0]  pos_y_i,
  input  logic signed [atb2d_pkg::DATA_W-1:0]  origin_x_i,
  input  logic signed [atb2d_pkg::DATA_W-1:0]  origin_y_i,
  input  logic signed [atb2d_pkg::DATA_W-1:0]  scale_x_i,
  input  logic signed [atb2d_pkg::DATA_W-1:0]  scale_y_i,
  input  logic        [atb2d_pkg::ROT_W-1:0]   rotation_i,
  output logic                                 done_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_a_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_b_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  trans_x_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_c_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  coef_d_o,
  output logic signed [atb2d_pkg::DATA_W-1:0]  trans_y_o
);

  localparam int unsigned NS  = atb2d_pkg::CORDIC_STAGES;
  localparam int unsigned AW  = atb2d_pkg::ANGLE_W;
  localparam int unsigned LAT = atb2d_pkg::LATENCY;
  localparam logic signed [31:0] ONE  = atb2d_pkg::CORDIC_ONE;
  localparam logic signed [31:0] MONE = -atb2d_pkg::CORDIC_ONE;

  logic                accept;
  logic [AW-1:0]       neg_rot, angle;
  logic                s0_valid_q;
  atb2d_pkg::quad_e    s0_quad_q;
  logic signed [31:0]  s0_z_q;

  atb2d_pkg::cordic_t  chain [0:NS];
  atb2d_pkg::payload_t pay_q [0:NS+1];

  logic signed [31:0]  cx, cy, cos_d, sin_d, cos_q, sin_q;
  logic                trig_valid_q;
  atb2d_pkg::trig_t    trig;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // The rotation is negated and widened to a 32-bit turn; the top two bits
  // give the quadrant and the rest is the CORDIC angle.
  assign neg_rot = AW'(0) - AW'(rotation_i);
  assign angle   = neg_rot << (AW - ANGLE_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      trig_valid_q <= 1'b0;
    end else begin
      s0_valid_q   <= accept;
      trig_valid_q <= chain[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_quad_q <= atb2d_pkg::quad_e'(angle[AW-1:AW-2]);
    s0_z_q    <= $signed({2'b00, angle[AW-3:0]});
    pay_q[0]  <= '{pos_x: pos_x_i, pos_y: pos_y_i, origin_x: origin_x_i,
                   origin_y: origin_y_i, scale_x: scale_x_i, scale_y: scale_y_i};
    for (int i = 1; i <= NS + 1; i++) begin
      pay_q[i] <= pay_q[i-1];
    end
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  assign chain[0] = '{valid: s0_valid_q, quad: s0_quad_q,
                      x: atb2d_pkg::CORDIC_GAIN_INV, y: 32'sd0, z: s0_z_q};

  for (genvar g = 0; g < NS; g++) begin : g_cell
    atb2d_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(chain[g]),
      .cell_o(chain[g+1])
    );
  end

  always_comb begin
    cx = (chain[NS].x > ONE) ? ONE : ((chain[NS].x < MONE) ? MONE : chain[NS].x);
    cy = (chain[NS].y > ONE) ? ONE : ((chain[NS].y < MONE) ? MONE : chain[NS].y);
    case (chain[NS].quad)
      atb2d_pkg::QUAD_0: begin
        cos_d = cx;
        sin_d = cy;
      end
      atb2d_pkg::QUAD_1: begin
        cos_d = -cy;
        sin_d = cx;
      end
      atb2d_pkg::QUAD_2: begin
        cos_d = -cx;
        sin_d = -cy;
      end
      default: begin
        cos_d = cy;
        sin_d = -cx;
      end
    endcase
  end

  assign trig = '{valid: trig_valid_q, cos_v: cos_q, sin_v: sin_q, pay: pay_q[NS+1]};

  atb2d_scale_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .trig_i   (trig),
    .done_o   (done_o),
    .coef_a_o (coef_a_o),
    .coef_b_o (coef_b_o),
    .trans_x_o(trans_x_o),
    .coef_c_o (coef_c_o),
    .coef_d_o (coef_d_o),
    .trans_y_o(trans_y_o)
  );

  `ATB2D_ASSERT_IMP(a_done_from_word, clk_i, rst_ni, done_o, $past(accept, LAT))
  `ATB2D_ASSERT_NXT(a_word_reaches_trig, clk_i, rst_ni, chain[NS].valid, trig.valid)
  `ATB2D_ASSERT_IMP(a_trig_in_range, clk_i, rst_ni, trig.valid, (trig.cos_v <= ONE) && (trig.cos_v >= MONE) && (trig.sin_v <= ONE) && (trig.sin_v >= MONE))

endmodule

### test/tb.sv
module tb;
  import atb2d_pkg::*;

  localparam int unsigned FRAC_W    = FRAC_BITS_DEF;
  localparam int unsigned ANGLE_W_T = ANGLE_BITS_DEF;
  localparam int unsigned N_RANDOM  = 2000;

  localparam logic signed [31:0] ONE_Q  = 32'sh0001_0000;
  localparam logic signed [31:0] MAX_Q  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_Q  = 32'sh8000_0000;
  localparam logic signed [31:0] HALF_Q = 32'sh0000_8000;

  typedef struct packed {
    payload_t    pay;
    logic [15:0] rotation;
  } placement_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] trans_x;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] trans_y;
  } matrix_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic signed [31:0] pos_x_i    = '0;
  logic signed [31:0] pos_y_i    = '0;
  logic signed [31:0] origin_x_i = '0;
  logic signed [31:0] origin_y_i = '0;
  logic signed [31:0] scale_x_i  = '0;
  logic signed [31:0] scale_y_i  = '0;
  logic        [15:0] rotation_i = '0;
  logic done_o;
  logic signed [31:0] coef_a_o, coef_b_o, trans_x_o, coef_c_o, coef_d_o, trans_y_o;

  // Arctangent of 2^-i in units of 2^-32 of a full turn.
  longint atan_step [0:29] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43,
    64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F,
    64'sh000A2F98, 64'sh000517CC, 64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA,
    64'sh0000517D, 64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
    64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051, 64'sh00000029,
    64'sh00000014, 64'sh0000000A, 64'sh00000005, 64'sh00000003, 64'sh00000001
  };

  placement_t pending_q[$];
  matrix_t    matrix_q[$];
  placement_t next_item;
  int unsigned n_items    = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_mismatch = 0;
  int unsigned idle_pct;

  affine_transform_builder_2d #(
    .FRAC_BITS (FRAC_W),
    .ANGLE_BITS(ANGLE_W_T)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .origin_x_i(origin_x_i),
    .origin_y_i(origin_y_i),
    .scale_x_i (scale_x_i),
    .scale_y_i (scale_y_i),
    .rotation_i(rotation_i),
    .done_o    (done_o),
    .coef_a_o  (coef_a_o),
    .coef_b_o  (coef_b_o),
    .trans_x_o (trans_x_o),
    .coef_c_o  (coef_c_o),
    .coef_d_o  (coef_d_o),
    .trans_y_o (trans_y_o)
  );

  always #5 clk_i = ~clk_i;

  // Round to nearest with ties toward plus infinity.
  function automatic longint round_shr(input longint v, input int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > longint'(MAX_Q)) begin
      return MAX_Q;
    end else if (v < longint'(MIN_Q)) begin
      return MIN_Q;
    end
    return v[31:0];
  endfunction

  function automatic matrix_t build_matrix(input placement_t p);
    logic [31:0] turn;
    quad_e quad;
    longint x, y, z, dx, dy, c, s;
    longint sx, sy, ox, oy, px, py;
    longint sxc, sys, sxs, syc, tx, ty;
    matrix_t m;
    // The rotation is negated and then mapped onto a 32-bit turn.
    turn = (32'd0 - {16'd0, p.rotation}) & ((32'd1 << ANGLE_W_T) - 32'd1);
    turn = turn << (32 - ANGLE_W_T);
    quad = quad_e'(turn[31:30]);
    z = longint'(turn[29:0]);
    x = longint'(CORDIC_GAIN_INV);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end
    end
    if (x > longint'(CORDIC_ONE)) x = longint'(CORDIC_ONE);
    if (x < -longint'(CORDIC_ONE)) x = -longint'(CORDIC_ONE);
    if (y > longint'(CORDIC_ONE)) y = longint'(CORDIC_ONE);
    if (y < -longint'(CORDIC_ONE)) y = -longint'(CORDIC_ONE);
    case (quad)
      QUAD_0: begin
        c = x;
        s = y;
      end
      QUAD_1: begin
        c = -y;
        s = x;
      end
      QUAD_2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    px = longint'(p.pay.pos_x);
    py = longint'(p.pay.pos_y);
    ox = longint'(p.pay.origin_x);
    oy = longint'(p.pay.origin_y);
    sx = longint'(p.pay.scale_x);
    sy = longint'(p.pay.scale_y);
    sxc = round_shr(sx * c, CORDIC_FRAC);
    sys = round_shr(sy * s, CORDIC_FRAC);
    sxs = round_shr(sx * s, CORDIC_FRAC);
    syc = round_shr(sy * c, CORDIC_FRAC);
    // The translation uses the coefficients before they are saturated.
    tx = px - round_shr(ox * sxc, FRAC_W) - round_shr(oy * sys, FRAC_W);
    ty = py + round_shr(ox * sxs, FRAC_W) - round_shr(oy * syc, FRAC_W);
    m.coef_a  = clip32(sxc);
    m.coef_b  = clip32(sys);
    m.trans_x = clip32(tx);
    m.coef_c  = clip32(-sxs);
    m.coef_d  = clip32(syc);
    m.trans_y = clip32(ty);
    return m;
  endfunction

  function automatic placement_t make_placement(
    input logic signed [31:0] px, py, ox, oy, sx, sy,
    input logic [15:0] rot
  );
    placement_t p;
    p.pay.pos_x    = px;
    p.pay.pos_y    = py;
    p.pay.origin_x = ox;
    p.pay.origin_y = oy;
    p.pay.scale_x  = sx;
    p.pay.scale_y  = sy;
    p.rotation     = rot;
    return p;
  endfunction

  function automatic logic signed [31:0] near_zero(input int unsigned bits);
    int v;
    v = int'($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits);
    return v;
  endfunction

  function automatic placement_t random_placement();
    placement_t p;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    p = make_placement($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       16'($urandom_range(0, 65535)));
    // Most words look like a real scene, so the outputs rarely saturate.
    if (mode >= 3) begin
      p.pay.pos_x    = near_zero(24);
      p.pay.pos_y    = near_zero(24);
      p.pay.origin_x = near_zero(22);
      p.pay.origin_y = near_zero(22);
      p.pay.scale_x  = near_zero(19);
      p.pay.scale_y  = near_zero(19);
    end
    if (mode == 3) begin
      p.pay.scale_x = ONE_Q;
      p.pay.scale_y = ONE_Q;
    end
    // Land on or right next to a quarter turn.
    if (mode == 9) begin
      p.rotation = (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
    end
    return p;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        matrix_q.push_back(build_matrix(next_item));
        n_accepted++;
      end
      if (n_accepted < n_items / 3) begin
        idle_pct = 18;
      end else if (n_accepted < 2 * n_items / 3) begin
        idle_pct = 85;
      end else begin
        idle_pct = 0;
      end
      if (start && busy) begin
        // The word stays on the bus until the block takes it.
      end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_item  = pending_q.pop_front();
        pos_x_i    <= next_item.pay.pos_x;
        pos_y_i    <= next_item.pay.pos_y;
        origin_x_i <= next_item.pay.origin_x;
        origin_y_i <= next_item.pay.origin_y;
        scale_x_i  <= next_item.pay.scale_x;
        scale_y_i  <= next_item.pay.scale_y;
        rotation_i <= next_item.rotation;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    matrix_t got;
    matrix_t want;
    if (rst_ni && done_o) begin
      got = '{coef_a_o, coef_b_o, trans_x_o, coef_c_o, coef_d_o, trans_y_o};
      n_results++;
      if (matrix_q.size() == 0) begin
        if (n_mismatch < 10) begin
          $display("unexpected result word: a=%h b=%h tx=%h c=%h d=%h ty=%h",
                   got.coef_a, got.coef_b, got.trans_x, got.coef_c, got.coef_d,
                   got.trans_y);
        end
        n_mismatch++;
      end else begin
        want = matrix_q.pop_front();
        if (got.coef_a !== want.coef_a || got.coef_b !== want.coef_b ||
            got.trans_x !== want.trans_x || got.coef_c !== want.coef_c ||
            got.coef_d !== want.coef_d || got.trans_y !== want.trans_y) begin
          if (n_mismatch < 10) begin
            $display("mismatch in result %0d", n_results);
            $display("  expected a=%h b=%h tx=%h c=%h d=%h ty=%h", want.coef_a,
                     want.coef_b, want.trans_x, want.coef_c, want.coef_d, want.trans_y);
            $display("  actual   a=%h b=%h tx=%h c=%h d=%h ty=%h", got.coef_a,
                     got.coef_b, got.trans_x, got.coef_c, got.coef_d, got.trans_y);
          end
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    // Directed words: zero, identity, quarter turns, saturation corners.
    pending_q.push_back(make_placement(0, 0, 0, 0, 0, 0, 16'd0));
    pending_q.push_back(make_placement(ONE_Q, -ONE_Q, HALF_Q, HALF_Q, ONE_Q, ONE_Q, 16'd0));
    pending_q.push_back(make_placement(ONE_Q, ONE_Q, ONE_Q, -ONE_Q, ONE_Q, ONE_Q, 16'd16384));
    pending_q.push_back(make_placement(ONE_Q, ONE_Q, ONE_Q, -ONE_Q, ONE_Q, ONE_Q, 16'd32768));
    pending_q.push_back(make_placement(ONE_Q, ONE_Q, ONE_Q, -ONE_Q, ONE_Q, ONE_Q, 16'd49152));
    pending_q.push_back(make_placement(0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 16'd1));
    pending_q.push_back(make_placement(0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 16'd65535));
    pending_q.push_back(make_placement(0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 16'd8192));
    pending_q.push_back(make_placement(0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 16'd16383));
    pending_q.push_back(make_placement(0, 0, ONE_Q, ONE_Q, 32'sd1, -32'sd1, 16'd0));
    pending_q.push_back(make_placement(0, 0, 0, 0, MAX_Q, MAX_Q, 16'd0));
    pending_q.push_back(make_placement(0, 0, 0, 0, MIN_Q, MIN_Q, 16'd32768));
    // Negating the most negative sine product must saturate.
    pending_q.push_back(make_placement(0, 0, 0, 0, MIN_Q, MIN_Q, 16'd16384));
    pending_q.push_back(make_placement(0, 0, 0, 0, MIN_Q, MAX_Q, 16'd49152));
    pending_q.push_back(make_placement(MAX_Q, MIN_Q, 0, 0, ONE_Q, ONE_Q, 16'd0));
    pending_q.push_back(make_placement(MIN_Q, MAX_Q, 0, 0, ONE_Q, ONE_Q, 16'd0));
    pending_q.push_back(make_placement(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 16'd0));
    pending_q.push_back(make_placement(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 16'd0));
    pending_q.push_back(make_placement(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 16'd65535));
    pending_q.push_back(make_placement(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 16'd32768));
    pending_q.push_back(make_placement(0, 0, MAX_Q, MIN_Q, MAX_Q, MIN_Q, 16'd24576));
    pending_q.push_back(make_placement(-1, -1, -1, -1, -1, -1, 16'd40960));
    for (int i = 0; i < N_RANDOM; i++) begin
      pending_q.push_back(random_placement());
    end
    n_items = pending_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_accepted < n_items) @(posedge clk_i);
    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Sent %0d placement words with sender gaps of 18, 85 and 0 percent;", n_items);
    $display("checked %0d matrix words, %0d of them wrong.", n_results, n_mismatch);
    if (n_mismatch == 0 && matrix_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
